### design/wmde_pkg.sv
package wmde_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int ROW_W   = 10;
  localparam int HGT_W   = ROW_W + 1;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 4;

  // Largest frame height that is honoured
  localparam int HEIGHT_LIMIT = 1024;

  // Register map indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_OPERATOR_MODE = 2'd2;

  // Reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  typedef enum logic {
    MODE_HOMOGENEITY = 1'b0,
    MODE_SYMMETRIC   = 1'b1
  } op_mode_t;

  typedef logic [PIX_W-1:0] pixel_t;

  function automatic pixel_t abs_diff(input pixel_t a, input pixel_t b);
    pixel_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

endpackage

### design/wmde_ram.sv
module wmde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/window_max_difference_edge_core.sv
// Streaming window edge detector for 8-bit grey pixels in raster order.
// Input channel: in_valid / in_stall / in_pixel, one pixel per transaction,
// frames of frame_width x frame_height pixels back to back.
// Output channel: out_valid / out_stall / out_edge_value / out_frame_last,
// one transaction per interior pixel (WINDOW-1 rows and columns of warm-up
// give none); out_frame_last marks the last interior pixel of a frame.
// operator_mode 0 gives the largest difference between the centre and any
// window pixel, 1 the largest difference over point-symmetric pairs.
// Configuration over the APB-style cfg_ port: frame_width at 0x0,
// frame_height at 0x4, operator_mode at 0x8; pready is tied high. Change
// registers only while the stream is idle.
// Throughput: one pixel per clock while out_stall is low, set by one
// line-store read and one write per cycle in each line RAM. Order: the line
// read happens at the pixel's transaction edge, then the window updates, and
// the result is presented from the output register.
// When out_stall is held, results back up through the window and read
// stages and in_stall rises once all three stages hold data.
// Reset clears the counters, window and pipeline; the line RAMs are not
// cleared, and stale reads reach only warm-up pixels that give no output.
module window_max_difference_edge_core #(
  parameter int WINDOW    = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wmde_pkg::PIX_W-1:0]          in_pixel,
  // Edge output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wmde_pkg::PIX_W-1:0]          out_edge_value,
  output logic                                out_frame_last,
  // Configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wmde_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [wmde_pkg::APB_W-1:0]          cfg_pwdata,
  output logic [wmde_pkg::APB_W-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CELLS  = WINDOW * WINDOW;
  localparam int HALF   = WINDOW / 2;
  localparam int PAIRS  = CELLS / 2;
  localparam int LINES  = WINDOW - 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int CMP_W  = (WID_W > wmde_pkg::CFG_W) ? WID_W : wmde_pkg::CFG_W;
  localparam int LEAVES = 2 ** $clog2(CELLS);
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int HGT_W  = wmde_pkg::HGT_W;
  localparam int ROW_W  = wmde_pkg::ROW_W;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [wmde_pkg::CFG_W-1:0] cfg_width_r;
  logic [wmde_pkg::CFG_W-1:0] cfg_height_r;
  wmde_pkg::op_mode_t         cfg_mode_r;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= wmde_pkg::FRAME_WIDTH_RST;
      cfg_height_r <= wmde_pkg::FRAME_HEIGHT_RST;
      cfg_mode_r   <= wmde_pkg::MODE_HOMOGENEITY;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wmde_pkg::REG_FRAME_WIDTH:   cfg_width_r  <= cfg_pwdata[wmde_pkg::CFG_W-1:0];
        wmde_pkg::REG_FRAME_HEIGHT:  cfg_height_r <= cfg_pwdata[wmde_pkg::CFG_W-1:0];
        wmde_pkg::REG_OPERATOR_MODE: cfg_mode_r   <= wmde_pkg::op_mode_t'(cfg_pwdata[0]);
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      wmde_pkg::REG_FRAME_WIDTH:   cfg_prdata = wmde_pkg::APB_W'(cfg_width_r);
      wmde_pkg::REG_FRAME_HEIGHT:  cfg_prdata = wmde_pkg::APB_W'(cfg_height_r);
      wmde_pkg::REG_OPERATOR_MODE: cfg_prdata = wmde_pkg::APB_W'(cfg_mode_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Frame size in use, clamped to the supported range
  // ---------------------------------------------------------------
  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] width_clamped;
  logic [WID_W-1:0] width_used;
  logic [HGT_W-1:0] height_used;

  assign width_ext = CMP_W'(cfg_width_r);

  always_comb begin
    if (width_ext < CMP_W'(WINDOW)) begin
      width_clamped = CMP_W'(WINDOW);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_clamped = CMP_W'(MAX_WIDTH);
    end else begin
      width_clamped = width_ext;
    end
    width_used = width_clamped[WID_W-1:0];

    if (cfg_height_r < HGT_W'(WINDOW)) begin
      height_used = HGT_W'(WINDOW);
    end else if (cfg_height_r > HGT_W'(wmde_pkg::HEIGHT_LIMIT)) begin
      height_used = HGT_W'(wmde_pkg::HEIGHT_LIMIT);
    end else begin
      height_used = cfg_height_r;
    end
  end

  // ---------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_free, s1_free;
  logic in_acc, s1_go, s2_go;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign s2_go    = s2_valid_r && out_free;

  // ---------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] col_pre, col_inc;
  logic [HGT_W-1:0] row_pre, row_inc, row_wrap;
  logic             emit_cur, last_cur;

  always_comb begin
    // wrap a position left outside the frame by a size change
    col_pre = {1'b0, col_r};
    row_pre = {1'b0, row_r};
    if (col_pre >= width_used) begin
      col_pre = '0;
      row_pre = row_pre + HGT_W'(1);
    end
    if (row_pre >= height_used) begin
      row_pre = '0;
    end

    // advance to the next pixel
    col_inc  = col_pre + WID_W'(1);
    row_inc  = row_pre + HGT_W'(1);
    row_wrap = (row_inc >= height_used) ? '0 : row_inc;
    if (col_inc >= width_used) begin
      col_nxt = '0;
      row_nxt = row_wrap[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_pre[ROW_W-1:0];
    end

    emit_cur = (row_pre >= HGT_W'(WINDOW - 1)) && (col_pre >= WID_W'(WINDOW - 1));
    last_cur = (row_pre == height_used - HGT_W'(1)) && (col_pre == width_used - WID_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: line-store read in flight
  // ---------------------------------------------------------------
  logic [wmde_pkg::PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0]           s1_col_r;
  logic                       s1_emit_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_pixel;
      s1_col_r  <= col_pre[COL_W-1:0];
      s1_emit_r <= emit_cur;
      s1_last_r <= last_cur;
    end
  end

  // ---------------------------------------------------------------
  // Line stores: read at acceptance, shifted up at stage 1
  // ---------------------------------------------------------------
  logic [wmde_pkg::PIX_W-1:0] line_rd [LINES];
  logic [wmde_pkg::PIX_W-1:0] line_wd [LINES];

  for (genvar l = 0; l < LINES; l++) begin : g_line
    if (l == LINES - 1) begin : g_top
      assign line_wd[l] = s1_pix_r;
    end else begin : g_mid
      assign line_wd[l] = line_rd[l+1];
    end

    wmde_ram #(
      .DATA_W (wmde_pkg::PIX_W),
      .DEPTH  (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (s1_go),
      .waddr (s1_col_r),
      .wdata (line_wd[l]),
      .re    (in_acc),
      .raddr (col_pre[COL_W-1:0]),
      .rdata (line_rd[l])
    );
  end

  // ---------------------------------------------------------------
  // Stage 2: window registers
  // ---------------------------------------------------------------
  logic [wmde_pkg::PIX_W-1:0] win_r [WINDOW][WINDOW];
  logic                       s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_go) begin
      s2_valid_r <= s1_emit_r;
      // shift left, new column from the line stores and the new pixel
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      for (int r = 0; r < LINES; r++) begin
        win_r[r][WINDOW-1] <= line_rd[r];
      end
      win_r[WINDOW-1][WINDOW-1] <= s1_pix_r;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------
  // Edge value: absolute differences, then a max tree
  // ---------------------------------------------------------------
  logic [wmde_pkg::PIX_W-1:0] node [NODES];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < CELLS) begin : g_cell
      localparam int M = CELLS - 1 - k;
      logic [wmde_pkg::PIX_W-1:0] d_centre;
      logic [wmde_pkg::PIX_W-1:0] d_pair;
      assign d_centre = wmde_pkg::abs_diff(win_r[HALF][HALF], win_r[k / WINDOW][k % WINDOW]);
      if (k < PAIRS) begin : g_pair
        assign d_pair = wmde_pkg::abs_diff(win_r[k / WINDOW][k % WINDOW],
                                           win_r[M / WINDOW][M % WINDOW]);
      end else begin : g_nopair
        assign d_pair = '0;
      end
      assign node[LEAVES-1+k] = (cfg_mode_r == wmde_pkg::MODE_SYMMETRIC) ? d_pair : d_centre;
    end else begin : g_pad
      assign node[LEAVES-1+k] = '0;
    end
  end

  for (genvar i = 0; i < LEAVES - 1; i++) begin : g_tree
    assign node[i] = (node[2*i+1] > node[2*i+2]) ? node[2*i+1] : node[2*i+2];
  end

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic [wmde_pkg::PIX_W-1:0] out_edge_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_edge_r <= node[0];
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_value = out_edge_r;
  assign out_frame_last = out_last_r;

endmodule
